// ===== rtl/sslb_pkg.sv =====
// ----------------------------------------------------------------------------
// sslb_pkg
// Types, constants and the line hit test shared by the scanline sprite list
// builder files.
// ----------------------------------------------------------------------------
package sslb_pkg;

   localparam int LineWidth    = 9;
   localparam int SpriteWidth  = 9;
   localparam int VctlWidth    = 16;
   localparam int SlotWidth    = 7;
   localparam int TopWidth     = 10;
   localparam int RowsWidth    = 6;

   // Sprites at or beyond this index are outside the sprite table
   localparam logic [SpriteWidth-1:0] SpriteTableSize = 9'd381;

   localparam logic [TopWidth-1:0]  TopBase   = 10'h200;
   localparam logic [RowsWidth-1:0] RowsLimit = 6'h20;
   localparam int                   ChainBit  = 6;

   typedef struct packed {
      logic                   entry_valid;
      logic [SlotWidth-1:0]   list_slot;
      logic [SpriteWidth-1:0] listed_sprite;
      logic                   list_bank;
      logic                   scan_done;
      logic [SlotWidth-1:0]   active_total;
   } rsp_payload_type;

   // True when the scanline falls within [top, top + height - 1] mod 512
   function automatic logic hits_line(logic [LineWidth-1:0] line,
                                      logic [TopWidth-1:0]  top,
                                      logic [RowsWidth-1:0] rows);
      logic [RowsWidth-1:0] eff_rows;
      logic [10:0]          height;
      logic [10:0]          sum;
      logic [LineWidth-1:0] bottom;
      logic [TopWidth-1:0]  line_x;
      logic [TopWidth-1:0]  bottom_x;
      eff_rows = (rows == '0 || rows > RowsLimit) ? RowsLimit : rows;
      height   = {1'b0, eff_rows, 4'b0000};
      sum      = {1'b0, top} + height - 11'd1;
      bottom   = sum[LineWidth-1:0];
      line_x   = {1'b0, line};
      bottom_x = {1'b0, bottom};
      if (bottom_x >= top) begin
         return (line_x >= top) && (line_x <= bottom_x);
      end
      return (line_x >= top) || (line_x <= bottom_x);
   endfunction

endpackage

// ===== rtl/sslb_if.sv =====
// ----------------------------------------------------------------------------
// sslb_req_if / sslb_rsp_if
// Valid/ready channels of the scanline sprite list builder.
// ----------------------------------------------------------------------------
interface sslb_req_if;
   logic        valid;
   logic        ready;
   logic        first_of_scan;
   logic        last_of_scan;
   logic [8:0]  line_number;
   logic [8:0]  sprite_id;
   logic [15:0] vertical_control;

   modport source (output valid, first_of_scan, last_of_scan, line_number,
                   sprite_id, vertical_control, input ready);
   modport sink   (input valid, first_of_scan, last_of_scan, line_number,
                   sprite_id, vertical_control, output ready);
endinterface

interface sslb_rsp_if;
   logic       valid;
   logic       ready;
   logic       entry_valid;
   logic [6:0] list_slot;
   logic [8:0] listed_sprite;
   logic       list_bank;
   logic       scan_done;
   logic [6:0] active_total;

   modport source (output valid, entry_valid, list_slot, listed_sprite,
                   list_bank, scan_done, active_total, input ready);
   modport sink   (input valid, entry_valid, list_slot, listed_sprite,
                   list_bank, scan_done, active_total, output ready);
endinterface

// ===== rtl/scanline_sprite_list_builder_core.sv =====
// ----------------------------------------------------------------------------
// scanline_sprite_list_builder_core
// Builds the active sprite list of one scanline from sprite vertical control
// words, one sprite per cycle, assigning consecutive list slots to hits.
// ----------------------------------------------------------------------------
//
//  channel | direction | payload
//  --------+-----------+-----------------------------------------------------
//  req     | in        | first/last of scan, line, sprite id, vertical word
//  rsp     | out       | entry, slot, sprite, bank, scan done, active total
//
//  One sprite per cycle sustained while rsp does not stall; a result passes
//  through the input register, then the result register, before it can
//  transfer on rsp.
//  The chain and count registers update as each sprite leaves the input
//  register, so the next sprite sees them in the following cycle.
//  Sprites that give no result drain without waiting on rsp.
//  A stall on rsp holds the result register, then the input register, then
//  drops req.ready. Reset clears the valid flags and the scan state.
//
module scanline_sprite_list_builder_core #(
   parameter int MAX_PER_LINE = 96
) (
   input logic        clock,
   input logic        reset,
   sslb_req_if.sink   req,
   sslb_rsp_if.source rsp
);
   import sslb_pkg::*;

   localparam logic [SlotWidth-1:0] MaxCount = SlotWidth'(MAX_PER_LINE);

   // Input register
   logic                   in_valid_ff,   in_valid_in;
   logic                   in_first_ff;
   logic                   in_last_ff;
   logic [LineWidth-1:0]   in_line_ff;
   logic [SpriteWidth-1:0] in_id_ff;
   logic [VctlWidth-1:0]   in_vctl_ff;

   // Scan state
   logic [TopWidth-1:0]    chain_top_ff,  chain_top_in;
   logic [RowsWidth-1:0]   chain_rows_ff, chain_rows_in;
   logic [SlotWidth-1:0]   count_ff,      count_in;

   // Result register
   logic                   out_valid_ff,  out_valid_in;
   rsp_payload_type        out_data_ff,   out_data_in;

   logic                   load_in;
   logic                   in_take;
   logic                   out_free;
   logic                   emit;
   logic                   advance;
   logic                   listed;
   logic [TopWidth-1:0]    base_top;
   logic [RowsWidth-1:0]   base_rows;
   logic [SlotWidth-1:0]   base_count;
   logic                   eligible;

   // Result register frees when empty or when its transfer completes
   assign out_free  = !out_valid_ff || rsp.ready;
   assign advance   = in_valid_ff && (!emit || out_free);
   assign req.ready = !in_valid_ff || advance;
   assign in_take   = req.valid && req.ready;

   always_comb begin
      // Start of scan clears count and chain values before the sprite
      base_top   = in_first_ff ? '0 : chain_top_ff;
      base_rows  = in_first_ff ? '0 : chain_rows_ff;
      base_count = in_first_ff ? '0 : count_ff;

      // Ignore sprites outside the table, and all sprites once the list is full
      eligible = (in_id_ff < SpriteTableSize) && (base_count < MaxCount);

      chain_top_in  = base_top;
      chain_rows_in = base_rows;
      if (eligible && !in_vctl_ff[ChainBit]) begin
         chain_top_in  = TopBase - {1'b0, in_vctl_ff[VctlWidth-1:7]};
         chain_rows_in = in_vctl_ff[RowsWidth-1:0];
      end

      listed   = eligible && (chain_rows_in != '0) &&
                 hits_line(in_line_ff, chain_top_in, chain_rows_in);
      count_in = listed ? base_count + SlotWidth'(1) : base_count;
      emit     = listed || in_last_ff;

      out_data_in.entry_valid   = listed;
      out_data_in.list_slot     = listed ? base_count : '0;
      out_data_in.listed_sprite = listed ? in_id_ff : '0;
      out_data_in.list_bank     = in_line_ff[0];
      out_data_in.scan_done     = in_last_ff;
      out_data_in.active_total  = count_in;

      in_valid_in = in_take || (in_valid_ff && !advance);
      load_in     = advance && emit;

      // Hold a stalled result, load a fresh one, drop one that was taken
      if (load_in) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         chain_top_ff  <= '0;
         chain_rows_ff <= '0;
         count_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            chain_top_ff  <= chain_top_in;
            chain_rows_ff <= chain_rows_in;
            count_ff      <= count_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (in_take) begin
         in_first_ff <= req.first_of_scan;
         in_last_ff  <= req.last_of_scan;
         in_line_ff  <= req.line_number;
         in_id_ff    <= req.sprite_id;
         in_vctl_ff  <= req.vertical_control;
      end
      if (load_in) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.entry_valid   = out_data_ff.entry_valid;
   assign rsp.list_slot     = out_data_ff.list_slot;
   assign rsp.listed_sprite = out_data_ff.listed_sprite;
   assign rsp.list_bank     = out_data_ff.list_bank;
   assign rsp.scan_done     = out_data_ff.scan_done;
   assign rsp.active_total  = out_data_ff.active_total;

endmodule

// ===== rtl/sslb_checker.sv =====
// ----------------------------------------------------------------------------
// sslb_checker
// Port level checks on the result channel of the sprite list builder.
// ----------------------------------------------------------------------------
module sslb_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       entry_valid,
   input logic [6:0] list_slot,
   input logic [8:0] listed_sprite,
   input logic       scan_done,
   input logic [6:0] active_total
);
   import sslb_pkg::*;

   // A stalled transfer holds its slot, running total and entry flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(list_slot) &&
         $stable(active_total) && $stable(entry_valid))
      else $error("rsp payload changed while stalled");

   // A result without an entry only closes a scan
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !entry_valid |-> scan_done && list_slot == 7'd0 &&
         listed_sprite == 9'd0)
      else $error("empty result outside end of scan");

   // The running total counts the entry just listed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && entry_valid |-> active_total == list_slot + 7'd1)
      else $error("active_total does not follow list_slot");

   // Only sprites inside the table get listed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && entry_valid |-> listed_sprite < SpriteTableSize)
      else $error("sprite beyond table listed");

endmodule

bind scanline_sprite_list_builder_core sslb_checker u_sslb_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .entry_valid   (rsp.entry_valid),
   .list_slot     (rsp.list_slot),
   .listed_sprite (rsp.listed_sprite),
   .scan_done     (rsp.scan_done),
   .active_total  (rsp.active_total)
);
